// ----- design/pfd_pkg.sv -----
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared types, constants and helpers for the Playfair digraph encryptor.
// ----------------------------------------------------------------------------
package pfd_pkg;

  localparam int LETTER_W   = 5;
  localparam int SIDE       = 5;
  localparam int IDX_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = SIDE * LETTER_W;

  localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
  localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;
  localparam logic [LETTER_W-1:0] LETTER_X = 5'd23;

  // register indexes below this one select a square row
  localparam logic [CFG_IDX_W-1:0] NUM_SQ_ROWS = CFG_IDX_W'(SIDE);

  typedef logic [LETTER_W-1:0] letter_t;
  typedef letter_t [SIDE-1:0]  row_t;
  typedef row_t [SIDE-1:0]     square_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } pos_t;

  // one group of result words: last index, fault flag, two letters
  typedef struct packed {
    logic [1:0] last;
    logic       fault;
    letter_t    code0;
    letter_t    code1;
  } grp_t;

  // a b c d e / f g h i k / l m n o p / q r s t u / v w x y z
  localparam square_t SQUARE_RESET = {25'd27025109, 25'd21613104, 25'd16201099,
                                      25'd10755269, 25'd4294688};

  function automatic logic [IDX_W-1:0] pos_inc(input logic [IDX_W-1:0] v);
    return (v == IDX_W'(SIDE - 1)) ? '0 : v + 1'b1;
  endfunction

  function automatic letter_t cell_at(input square_t sq, input pos_t p);
    return sq[p.row][p.col];
  endfunction

endpackage

// ----- design/pfd_in_if.sv -----
// ----------------------------------------------------------------------------
// pfd_in_if
// Plaintext letter channel.
// ----------------------------------------------------------------------------
interface pfd_in_if;
  import pfd_pkg::*;

  logic    valid;
  logic    ready;
  letter_t plain_letter;
  logic    message_end;

  modport source (output valid, output plain_letter, output message_end, input ready);
  modport sink   (input valid, input plain_letter, input message_end, output ready);

endinterface

// ----- design/pfd_out_if.sv -----
// ----------------------------------------------------------------------------
// pfd_out_if
// Ciphertext result channel.
// ----------------------------------------------------------------------------
interface pfd_out_if;
  import pfd_pkg::*;

  logic    valid;
  logic    ready;
  letter_t cipher_letter;
  logic    repeated_x_fault;
  logic    run_last;

  modport source (output valid, output cipher_letter, output repeated_x_fault,
                  output run_last, input ready);
  modport sink   (input valid, input cipher_letter, input repeated_x_fault,
                  input run_last, output ready);

endinterface

// ----- design/pfd_cfg_if.sv -----
// ----------------------------------------------------------------------------
// pfd_cfg_if
// Configuration write channel for the key square rows.
// ----------------------------------------------------------------------------
interface pfd_cfg_if;
  import pfd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);

endinterface

// ----- design/pfd_locate.sv -----
// ----------------------------------------------------------------------------
// pfd_locate
// Finds the first square cell, row-major, holding a letter; cell 0 if none.
// ----------------------------------------------------------------------------
module pfd_locate (
  input  pfd_pkg::square_t square,
  input  pfd_pkg::letter_t letter,
  output pfd_pkg::pos_t    pos
);
  import pfd_pkg::*;

  // scan backwards so the earliest match is the one that sticks
  always_comb begin
    pos = '0;
    for (int r = SIDE - 1; r >= 0; r--) begin
      for (int c = SIDE - 1; c >= 0; c--) begin
        if (square[r][c] == letter) begin
          pos.row = IDX_W'(r);
          pos.col = IDX_W'(c);
        end
      end
    end
  end

endmodule

// ----- design/pfd_pair_cipher.sv -----
// ----------------------------------------------------------------------------
// pfd_pair_cipher
// Encrypts one digraph given the square positions of its two letters.
// ----------------------------------------------------------------------------
module pfd_pair_cipher (
  input  pfd_pkg::square_t square,
  input  pfd_pkg::pos_t    pos_a,
  input  pfd_pkg::pos_t    pos_b,
  output pfd_pkg::letter_t code_a,
  output pfd_pkg::letter_t code_b
);
  import pfd_pkg::*;

  pos_t qa;
  pos_t qb;

  always_comb begin
    qa = pos_a;
    qb = pos_b;
    priority if (pos_a.row == pos_b.row) begin
      qa.col = pos_inc(pos_a.col);
      qb.col = pos_inc(pos_b.col);
    end else if (pos_a.col == pos_b.col) begin
      qa.row = pos_inc(pos_a.row);
      qb.row = pos_inc(pos_b.row);
    end else begin
      qa.col = pos_b.col;
      qb.col = pos_a.col;
    end
  end

  assign code_a = cell_at(square, qa);
  assign code_b = cell_at(square, qb);

endmodule

// ----- design/playfair_digraph_encrypt_core.sv -----
// ----------------------------------------------------------------------------
// playfair_digraph_encrypt_core
// Playfair encryptor: pairs plaintext letters, splits doubles and pads with x.
// A letter is registered in the input register on acceptance; its result words
// are loaded into the result group register when the pairing step takes it.
// The core takes one letter per cycle; letters that give no word never wait,
// and one that gives words waits while an earlier group of words drains.
// Reset: square returns to the alphabetic key square, pairing state clears.
// ----------------------------------------------------------------------------
module playfair_digraph_encrypt_core (
  input  logic clk,
  input  logic rst,
  pfd_in_if.sink    letters,
  pfd_out_if.source cipher,
  pfd_cfg_if.sink   cfg
);
  import pfd_pkg::*;

  square_t    square;

  logic       in_valid;
  letter_t    in_letter;
  logic       in_end;

  letter_t    held_letter;
  letter_t    held_letter_next;
  logic       held_valid;
  logic       held_valid_next;
  logic       aborted;
  logic       aborted_next;

  logic       grp_valid;
  grp_t       grp;
  grp_t       grp_next;
  logic [1:0] grp_idx;
  logic       emit;

  pos_t       held_pos;
  pos_t       new_pos;
  pos_t       x_pos;
  pos_t       pad_pos;
  letter_t    pair_a;
  letter_t    pair_b;
  letter_t    pad_a;
  letter_t    pad_b;
  logic       pad_fault;

  logic       out_take;
  logic       grp_done;
  logic       step;

  // config
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      square <= SQUARE_RESET;
    end else if (cfg.valid && (cfg.index < NUM_SQ_ROWS)) begin
      square[cfg.index] <= cfg.data;
    end
  end

  // handshake
  assign out_take      = grp_valid && cipher.ready;
  assign grp_done      = out_take && (grp_idx == grp.last);
  assign step          = in_valid && (!emit || !grp_valid || grp_done);
  assign letters.ready = !in_valid || step;

  // input register, j folded onto i
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (letters.valid && letters.ready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (letters.valid && letters.ready) begin
      in_letter <= (letters.plain_letter == LETTER_J) ? LETTER_I : letters.plain_letter;
      in_end    <= letters.message_end;
    end
  end

  // square lookups
  pfd_locate u_loc_held (.square(square), .letter(held_letter), .pos(held_pos));
  pfd_locate u_loc_new  (.square(square), .letter(in_letter),   .pos(new_pos));
  pfd_locate u_loc_x    (.square(square), .letter(LETTER_X),    .pos(x_pos));

  assign pad_pos   = held_valid ? held_pos : new_pos;
  assign pad_fault = (pad_pos == x_pos);

  pfd_pair_cipher u_pair (
    .square(square), .pos_a(held_pos), .pos_b(new_pos), .code_a(pair_a), .code_b(pair_b)
  );

  pfd_pair_cipher u_pad (
    .square(square), .pos_a(pad_pos), .pos_b(x_pos), .code_a(pad_a), .code_b(pad_b)
  );

  // pairing decision
  always_comb begin
    held_letter_next = held_letter;
    held_valid_next  = held_valid;
    aborted_next     = aborted;
    emit             = 1'b0;
    grp_next         = '{last: 2'd1, fault: 1'b0, code0: pad_a, code1: pad_b};
    priority if (aborted) begin
      if (in_end) begin
        aborted_next    = 1'b0;
        held_valid_next = 1'b0;
      end
    end else if (!held_valid) begin
      if (!in_end) begin
        held_letter_next = in_letter;
        held_valid_next  = 1'b1;
      end else begin
        emit = 1'b1;
        if (pad_fault) begin
          grp_next = '{last: 2'd0, fault: 1'b1, code0: '0, code1: '0};
        end
      end
    end else if (held_pos != new_pos) begin
      emit            = 1'b1;
      held_valid_next = 1'b0;
      grp_next        = '{last: 2'd1, fault: 1'b0, code0: pair_a, code1: pair_b};
    end else if (pad_fault) begin
      emit            = 1'b1;
      held_valid_next = 1'b0;
      aborted_next    = !in_end;
      grp_next        = '{last: 2'd0, fault: 1'b1, code0: '0, code1: '0};
    end else begin
      // double letter: pad the held one; at message end the new one pads identically
      emit             = 1'b1;
      held_letter_next = in_letter;
      held_valid_next  = !in_end;
      if (in_end) begin
        grp_next.last = 2'd3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_letter <= '0;
      held_valid  <= 1'b0;
      aborted     <= 1'b0;
    end else if (step) begin
      held_letter <= held_letter_next;
      held_valid  <= held_valid_next;
      aborted     <= aborted_next;
    end
  end

  // result group register
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      grp_idx   <= '0;
    end else if (step && emit) begin
      grp_valid <= 1'b1;
      grp_idx   <= '0;
    end else if (grp_done) begin
      grp_valid <= 1'b0;
    end else if (out_take) begin
      grp_idx <= grp_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      grp <= grp_next;
    end
  end

  assign cipher.valid            = grp_valid;
  assign cipher.cipher_letter    = grp_idx[0] ? grp.code1 : grp.code0;
  assign cipher.repeated_x_fault = grp.fault;
  assign cipher.run_last         = (grp_idx == grp.last);

endmodule

// ----- tb/playfair_digraph_encrypt_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_digraph_encrypt_core_test
// Self-checking bench for the Playfair encryptor. Plaintext letters are sent
// as messages over the letter channel. Each accepted letter is run through a
// behavioural model of the pairing and square lookup. The model queues the
// cipher words that the letter should produce, and every word seen on the
// result channel is compared against the oldest queued word. The square is
// reloaded between phases: alphabetic, all zeros, all ones, shuffled keyword
// squares and random bit patterns. Both channels stall at random, with one
// long result hold-off, and the last phase runs without stalls.
// ----------------------------------------------------------------------------
module playfair_digraph_encrypt_core_test;
  import pfd_pkg::*;

  typedef enum logic [CFG_IDX_W-1:0] {
    SQ_ROW0, SQ_ROW1, SQ_ROW2, SQ_ROW3, SQ_ROW4
  } sq_reg_e;

  typedef struct packed {
    letter_t letter;
    logic    fault;
    logic    last;
  } cipher_word_t;

  typedef logic [CFG_DATA_W-1:0] sq_rows_t [SIDE];

  localparam int SETTLE_CYCLES = 6;

  logic clk;
  logic rst;

  pfd_in_if  letters_if ();
  pfd_out_if cipher_if ();
  pfd_cfg_if cfg_if ();

  playfair_digraph_encrypt_core dut (
    .clk     (clk),
    .rst     (rst),
    .letters (letters_if),
    .cipher  (cipher_if),
    .cfg     (cfg_if)
  );

  // model state
  logic [CFG_DATA_W-1:0] sq_rows [SIDE];
  letter_t               held_letter;
  logic                  held_valid;
  logic                  aborted;

  cipher_word_t expected_words [$];
  cipher_word_t group_words [$];

  int fail_count   = 0;
  int items_sent   = 0;
  int hold_request = 0;
  bit quiet        = 1'b0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #2_000_000;
    $display("** playfair_digraph_encrypt_core: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------- model --

  function automatic letter_t square_cell(input int p);
    int r;
    int c;
    r = (p / SIDE) % SIDE;
    c = p % SIDE;
    return letter_t'(sq_rows[r] >> (LETTER_W * c));
  endfunction

  // first matching cell, row-major; unknown letters map to cell 0
  function automatic int locate(input letter_t ltr);
    for (int p = 0; p < SIDE * SIDE; p++)
      if (square_cell(p) == ltr) return p;
    return 0;
  endfunction

  function automatic void emit(input letter_t ltr, input logic fault);
    cipher_word_t w;
    w.letter = ltr;
    w.fault  = fault;
    w.last   = 1'b0;
    group_words = {group_words, w};
  endfunction

  function automatic void encrypt_pair(input int p1, input int p2);
    int r1, c1, r2, c2, q1, q2;
    r1 = p1 / SIDE;
    c1 = p1 % SIDE;
    r2 = p2 / SIDE;
    c2 = p2 % SIDE;
    if (r1 == r2) begin
      q1 = r1 * SIDE + (c1 + 1) % SIDE;
      q2 = r2 * SIDE + (c2 + 1) % SIDE;
    end else if (c1 == c2) begin
      q1 = ((r1 + 1) % SIDE) * SIDE + c1;
      q2 = ((r2 + 1) % SIDE) * SIDE + c2;
    end else begin
      q1 = r1 * SIDE + c2;
      q2 = r2 * SIDE + c1;
    end
    emit(square_cell(q1), 1'b0);
    emit(square_cell(q2), 1'b0);
  endfunction

  // returns 1 when the letter sits on the x cell
  function automatic logic pad_with_x(input letter_t ltr);
    int p1;
    int px;
    p1 = locate(ltr);
    px = locate(LETTER_X);
    if (p1 == px) begin
      emit('0, 1'b1);
      return 1'b1;
    end
    encrypt_pair(p1, px);
    return 1'b0;
  endfunction

  function automatic void predict_letter(input letter_t ltr_in, input logic msg_end);
    letter_t ltr;
    int      p1;
    int      p2;
    logic    fault;
    ltr   = (ltr_in == LETTER_J) ? LETTER_I : ltr_in;
    fault = 1'b0;
    group_words.delete();
    if (aborted) begin
      if (msg_end) begin
        aborted    = 1'b0;
        held_valid = 1'b0;
      end
      return;
    end
    if (!held_valid) begin
      if (!msg_end) begin
        held_letter = ltr;
        held_valid  = 1'b1;
        return;
      end
      fault = pad_with_x(ltr);
    end else begin
      p1 = locate(held_letter);
      p2 = locate(ltr);
      held_valid = 1'b0;
      if (p1 == p2) begin
        fault = pad_with_x(held_letter);
        if (!fault) begin
          if (msg_end) fault = pad_with_x(ltr);
          else begin
            held_letter = ltr;
            held_valid  = 1'b1;
          end
        end
      end else begin
        encrypt_pair(p1, p2);
      end
    end
    if (fault) begin
      held_valid = 1'b0;
      if (!msg_end) aborted = 1'b1;
    end
    if (msg_end) held_valid = 1'b0;
    if (group_words.size() > 0) begin
      group_words[group_words.size() - 1].last = 1'b1;
      expected_words = {expected_words, group_words};
    end
  endfunction

  // --------------------------------------------------------- result check --

  initial begin : cipher_sink
    int           stall_left;
    int           hold_left;
    cipher_word_t want;
    stall_left = 0;
    hold_left  = 0;
    cipher_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && cipher_if.valid && cipher_if.ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: cipher_letter %0d repeated_x_fault %0b run_last %0b",
                 cipher_if.cipher_letter, cipher_if.repeated_x_fault, cipher_if.run_last);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (cipher_if.cipher_letter !== want.letter) begin
            $error("cipher_letter: expected %0d, actual %0d",
                   want.letter, cipher_if.cipher_letter);
            fail_count++;
          end
          if (cipher_if.repeated_x_fault !== want.fault) begin
            $error("repeated_x_fault: expected %0b, actual %0b",
                   want.fault, cipher_if.repeated_x_fault);
            fail_count++;
          end
          if (cipher_if.run_last !== want.last) begin
            $error("run_last: expected %0b, actual %0b", want.last, cipher_if.run_last);
            fail_count++;
          end
        end
      end
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        cipher_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        cipher_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 3) - 1;
        cipher_if.ready <= 1'b0;
      end else begin
        cipher_if.ready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------- drivers --

  task automatic send_letter(input letter_t ltr, input logic msg_end);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      letters_if.valid <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
    end
    letters_if.valid        <= 1'b1;
    letters_if.plain_letter <= ltr;
    letters_if.message_end  <= msg_end;
    do @(posedge clk); while (!letters_if.ready);
    predict_letter(ltr, msg_end);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_letter(letter_t'(s[i] - "a"), i == s.len() - 1);
  endtask

  // doubles and x are favoured so splits, pads and aborts turn up often
  task automatic send_random_message();
    int      len;
    int      pick;
    letter_t prev;
    letter_t ltr;
    len  = $urandom_range(1, 9);
    prev = letter_t'($urandom_range(0, 25));
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 4 && i > 0) ltr = prev;
      else if (pick < 6) ltr = LETTER_X;
      else if (pick == 6) ltr = LETTER_J;
      else ltr = letter_t'($urandom_range(0, 25));
      send_letter(ltr, i == len - 1);
      prev = ltr;
    end
  endtask

  task automatic send_random_items(input int count);
    int start;
    start = items_sent;
    while (items_sent - start < count) send_random_message();
  endtask

  task automatic wait_drained();
    letters_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_square(input sq_rows_t rows);
    for (int r = 0; r < SIDE; r++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= sq_reg_e'(r);
      cfg_if.data  <= rows[r];
      do @(posedge clk); while (!cfg_if.ready);
      sq_rows[r] = rows[r];
    end
    cfg_if.valid <= 1'b0;
  endtask

  // keyword-style shuffle without j; some squares get stray or random codes
  task automatic load_random_square(input int mode);
    sq_rows_t rows;
    letter_t  pool [$];
    letter_t  tmp;
    int       k;
    for (int l = 0; l < 26; l++)
      if (letter_t'(l) != LETTER_J) pool = {pool, letter_t'(l)};
    for (int i = SIDE * SIDE - 1; i > 0; i--) begin
      k       = $urandom_range(0, i);
      tmp     = pool[i];
      pool[i] = pool[k];
      pool[k] = tmp;
    end
    if (mode == 2) begin
      pool[$urandom_range(0, 24)] = letter_t'($urandom_range(0, 31));
      pool[$urandom_range(0, 24)] = letter_t'($urandom_range(0, 31));
    end
    for (int r = 0; r < SIDE; r++) begin
      rows[r] = '0;
      for (int c = 0; c < SIDE; c++)
        rows[r][LETTER_W * c +: LETTER_W] = pool[r * SIDE + c];
      if (mode == 1) rows[r] = CFG_DATA_W'($urandom);
    end
    write_square(rows);
  endtask

  // ---------------------------------------------------------------- tests --

  task automatic test_reset_square();
    send_text("hello");   // split of a double
    send_text("ae");      // same row, wrap
    send_text("ez");      // same column, wrap
    send_text("ji");      // j read as i, double at message end
    send_text("z");       // odd final letter padded
    send_text("xxybc");   // x x aborts, rest ignored to the end
    send_text("x");       // lone x faults on padding
    send_text("az");
    send_text("bb");
    send_text("xx");      // x x pair at message end
    wait_drained();
  endtask

  task automatic test_square_extremes();
    sq_rows_t rows;
    foreach (rows[r]) rows[r] = '0;
    write_square(rows);
    send_text("ab");
    send_text("qrs");
    wait_drained();
    foreach (rows[r]) rows[r] = '1;
    write_square(rows);
    send_text("cd");
    send_text("x");
    send_text("mnoz");
    wait_drained();
    foreach (rows[r]) rows[r] = SQUARE_RESET[r];
    write_square(rows);
    send_random_items(15);
    wait_drained();
  endtask

  task automatic test_random_squares();
    for (int phase = 0; phase < 6; phase++) begin
      load_random_square((phase == 2) ? 1 : (phase == 4) ? 2 : 0);
      send_random_items(18);
      wait_drained();
    end
  endtask

  task automatic test_result_backpressure();
    load_random_square(0);
    hold_request = 80;
    send_random_items(40);
    wait_drained();
  endtask

  task automatic test_quiet_finish();
    quiet = 1'b1;
    load_random_square(0);
    send_random_items(40);
    wait_drained();
  endtask

  initial begin
    rst                     <= 1'b1;
    letters_if.valid        <= 1'b0;
    letters_if.plain_letter <= '0;
    letters_if.message_end  <= 1'b0;
    cfg_if.valid            <= 1'b0;
    cfg_if.index            <= SQ_ROW0;
    cfg_if.data             <= '0;
    for (int r = 0; r < SIDE; r++) sq_rows[r] = SQUARE_RESET[r];
    held_letter = '0;
    held_valid  = 1'b0;
    aborted     = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_square();
    test_square_extremes();
    test_random_squares();
    test_result_backpressure();
    test_quiet_finish();

    if (fail_count == 0) begin
      $display("** playfair_digraph_encrypt_core: PASSED **");
    end else begin
      $display("** playfair_digraph_encrypt_core: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/pfd_pkg.sv
design/pfd_in_if.sv
design/pfd_out_if.sv
design/pfd_cfg_if.sv
design/pfd_locate.sv
design/pfd_pair_cipher.sv
design/playfair_digraph_encrypt_core.sv
tb/playfair_digraph_encrypt_core_test.sv
